@@ hw/rtl/ahts_pkg.sv @@
// Package for the additive harmonic tone synthesizer.
// Holds shared widths, envelope and weight constants, register indexes and ROM helpers.
// No dependencies.
`timescale 1ns / 1ps

package ahts_pkg;

  // Default configuration of the synthesizer.
  localparam int DEF_BLOCK_LEN      = 128;
  localparam int DEF_TABLE_SIZE     = 1024;
  localparam int DEF_HARMONIC_COUNT = 13;
  localparam int DEF_DAC_BITS       = 10;

  // Fixed state widths.
  localparam int PHASE_W = 32;
  localparam int TIME_W  = 18;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 32;
  localparam int REG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK_SAMPLES = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECAY_SAMPLES  = 2'd2;

  // Register reset values.
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd407486240;
  localparam logic [15:0]        ATTACK_RST     = 16'd827;
  localparam logic [15:0]        DECAY_RST      = 16'd3307;

  // Envelope stage codes.
  localparam logic [1:0] STAGE_ATTACK  = 2'd0;
  localparam logic [1:0] STAGE_DECAY   = 2'd1;
  localparam logic [1:0] STAGE_SUSTAIN = 2'd2;

  // Envelope gains in Q1.15.
  localparam logic [GAIN_W-1:0] GAIN_LOW     = 16'd6554;
  localparam logic [GAIN_W-1:0] GAIN_ONE     = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_SUSTAIN = 16'd26214;
  localparam logic [GAIN_W-1:0] GAIN_RISE    = 16'd26214;
  localparam logic [GAIN_W-1:0] GAIN_FALL    = 16'd6554;

  // Shared divider: divisor width covers 16-bit lengths and the weight sum.
  localparam int DIV_W = 18;
  // Envelope product width: 15-bit coefficient times 18-bit time.
  localparam int ENV_MUL_W = 33;

  // Harmonic weights in Q1.15 and the index width into them.
  localparam int WEIGHT_N = 13;
  localparam int WIDX_W   = 4;
  localparam logic [15:0] WEIGHTS [WEIGHT_N] = '{
    16'd32768, 16'd25713, 16'd27306, 16'd24468, 16'd13327, 16'd13835, 16'd10214,
    16'd8556,  16'd6717,  16'd4506,  16'd3296,  16'd2156,  16'd1402
  };

  // Quarter-turn angle in Q30 and the Taylor series divisors (2k)(2k+1).
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [6] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
  };

  // Sum of the first count weights.
  function automatic logic [DIV_W-1:0] weight_total(input int count);
    logic [DIV_W-1:0] total;
    total = '0;
    for (int i = 0; i < WEIGHT_N; i++) begin
      if (i < count) begin
        total = total + DIV_W'(WEIGHTS[i]);
      end
    end
    return total;
  endfunction

  // Sine magnitude of a Q30 angle in the first quadrant, rounded to Q15.
  function automatic logic [15:0] quarter_sine(input longint unsigned angle);
    longint unsigned term;
    longint          acc;
    term = angle;
    acc  = longint'(angle);
    for (int k = 0; k < 6; k++) begin
      term = (term * angle) >> 30;
      term = (term * angle) >> 30;
      term = term / TAYLOR_DIV[k];
      if ((k & 1) == 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return 16'(acc);
  endfunction

endpackage

@@ hw/rtl/additive_harmonic_tone_synth_top.sv @@
// Top level of the additive harmonic tone synthesizer: sine ROM, envelope, shared MAC and divider.
// Depends on ahts_pkg for constants, weights and the ROM generator function.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    restart
//   out      output     out_valid / out_stall  sample_code, envelope_stage
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// On a block's first tick in attack or decay, the bit-serial divider computes the envelope
// gain before the harmonic loop starts; the next transaction is accepted once the result
// has been handed over.
// rst is synchronous and active high; it restores register defaults and the note start.
// The input is stalled while a transaction is in work. A stalled result holds the next one
// in the final state, and the input stays stalled until that one can be handed over.
`timescale 1ns / 1ps

module additive_harmonic_tone_synth_top
  import ahts_pkg::*;
#(
  parameter int BLOCK_LEN      = DEF_BLOCK_LEN,
  parameter int TABLE_SIZE     = DEF_TABLE_SIZE,
  parameter int HARMONIC_COUNT = DEF_HARMONIC_COUNT,
  parameter int DAC_BITS       = DEF_DAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DAC_BITS-1:0]  sample_code,
  output logic [1:0]           envelope_stage,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Derived widths.
  localparam int POS_W    = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int ADDR_W   = $clog2(TABLE_SIZE);
  localparam int AP_W     = PHASE_W + ADDR_W;
  localparam int ISS_W    = $clog2(HARMONIC_COUNT + 1);
  localparam int QUO_W    = GAIN_W - 1;
  localparam int NUM_W    = QUO_W + DIV_W;
  localparam int CNT_W    = $clog2(QUO_W);
  localparam int MPROD_W  = 33;
  localparam int SUM_W    = 35;
  localparam int SCALE_W  = 52;
  localparam int X_W      = SCALE_W - 15;
  localparam int Y_W      = X_W + DAC_BITS + 1;
  localparam int N_W      = Y_W - 16;
  localparam int Q0_W     = N_W - 14;
  localparam int RP_W     = N_W + Q0_W;
  localparam int ENV_W    = TIME_W + 1;

  localparam logic [DIV_W-1:0]          WEIGHT_SUM = weight_total(HARMONIC_COUNT);
  localparam logic signed [SCALE_W-1:0] CODE_BIAS  = SCALE_W'(WEIGHT_SUM) << 30;
  localparam logic [TIME_W-1:0]         TIME_MAX   = '1;
  // Reciprocal of the weight sum, scaled by two to the N_W.
  localparam longint unsigned           RECIP_L    = (64'd1 << N_W) / 64'(WEIGHT_SUM);
  localparam logic [Q0_W-1:0]           RECIP      = Q0_W'(RECIP_L);

  // Sequencer states.
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ENV_SET  = 8'b0000_0010,
    ST_ENV_DIV  = 8'b0000_0100,
    ST_MAC      = 8'b0000_1000,
    ST_SCALE    = 8'b0001_0000,
    ST_CODE_MUL = 8'b0010_0000,
    ST_CODE_FIX = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration and note state.
  logic [PHASE_W-1:0] phase_step;
  logic [15:0]        attack_samples;
  logic [15:0]        decay_samples;
  logic [PHASE_W-1:0] phase_acc;
  logic [TIME_W-1:0]  sample_time;
  logic [POS_W-1:0]   block_position;
  logic [GAIN_W-1:0]  envelope_gain;
  logic [1:0]         stage_latch;

  // Harmonic multiply-accumulate pipeline.
  logic [PHASE_W-1:0]        harm_phase;
  logic [ISS_W-1:0]          issue_cnt;
  logic                      rom_valid;
  logic                      prod_valid;
  logic [WIDX_W-1:0]         rom_widx;
  logic signed [15:0]        rom_data;
  logic signed [MPROD_W-1:0] mac_prod;
  logic signed [SUM_W-1:0]   mac_sum;
  logic signed [SCALE_W-1:0] scale_prod;
  logic [AP_W-1:0]           addr_prod;
  logic [ADDR_W-1:0]         rom_addr;
  logic                      mac_issue;

  // Shared restoring divider.
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] div_den;
  logic [QUO_W-1:0] div_shift;
  logic [CNT_W-1:0] div_cnt;
  logic [DIV_W:0]   div_cand;
  logic             div_ge;
  logic [DIV_W-1:0] div_rem_next;
  logic [QUO_W-1:0] div_shift_next;
  logic             div_last;

  // Envelope and output code datapath.
  logic [ENV_W-1:0]         env_time;
  logic [ENV_W-1:0]         env_attack_end;
  logic [ENV_W-1:0]         env_decay_end;
  logic [ENV_W-1:0]         env_since_attack;
  logic                     env_in_attack;
  logic                     env_in_decay;
  logic [ENV_MUL_W-1:0]     env_prod;
  logic [NUM_W-1:0]         env_num;
  logic [DIV_W-1:0]         env_den;
  logic signed [SCALE_W-1:0] code_num;
  logic [SCALE_W-1:0]       code_pos;
  logic [X_W-1:0]           code_x;
  logic [Y_W-1:0]           code_y;
  logic [N_W-1:0]           code_n;
  logic [RP_W-1:0]          code_rp;
  logic [Q0_W-1:0]          code_q0;
  logic [N_W-1:0]           code_rem_full;
  logic [DIV_W:0]           code_rem;
  logic [Q0_W-1:0]          code_q;
  logic [DAC_BITS-1:0]      code_clamped;

  // Sine ROM, built at elaboration by quadrant folding.
  logic signed [15:0] sine_rom [TABLE_SIZE];

  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
    localparam longint unsigned QUAD     = (4 * k) / TABLE_SIZE;
    localparam longint unsigned REM_RAW  = (4 * k) % TABLE_SIZE;
    localparam longint unsigned REM_FOLD = (QUAD % 2 == 1) ? TABLE_SIZE - REM_RAW : REM_RAW;
    localparam longint unsigned ANGLE    = (REM_FOLD * HALF_PI_Q30) / TABLE_SIZE;
    localparam logic [15:0]     MAG      = quarter_sine(ANGLE);
    assign sine_rom[k] = (QUAD >= 2) ? -MAG : MAG;
  end

  assign in_stall = (state != ST_IDLE);

  // ROM address: top bits of the harmonic phase scaled to the table size.
  always_comb begin
    addr_prod = AP_W'(harm_phase) * AP_W'(TABLE_SIZE);
    rom_addr  = addr_prod[PHASE_W +: ADDR_W];
    mac_issue = (state == ST_MAC) && (issue_cnt != ISS_W'(HARMONIC_COUNT));
  end

  // One restoring division step.
  always_comb begin
    div_cand       = {div_rem, div_shift[QUO_W-1]};
    div_ge         = (div_cand >= {1'b0, div_den});
    div_rem_next   = div_ge ? DIV_W'(div_cand - {1'b0, div_den}) : div_cand[DIV_W-1:0];
    div_shift_next = {div_shift[QUO_W-2:0], div_ge};
    div_last       = (div_cnt == CNT_W'(QUO_W - 1));
  end

  // Envelope segment decision and the product that feeds the divider.
  always_comb begin
    env_time         = ENV_W'(sample_time);
    env_attack_end   = ENV_W'(attack_samples);
    env_decay_end    = ENV_W'(attack_samples) + ENV_W'(decay_samples);
    env_since_attack = env_time - env_attack_end;
    env_in_attack    = (env_time < env_attack_end);
    env_in_decay     = (env_time < env_decay_end);
    if (env_in_attack) begin
      env_prod = ENV_MUL_W'(GAIN_RISE) * ENV_MUL_W'(sample_time);
      env_den  = DIV_W'(attack_samples);
    end else begin
      env_prod = ENV_MUL_W'(GAIN_FALL) * ENV_MUL_W'(env_since_attack[TIME_W-1:0]);
      env_den  = DIV_W'(decay_samples);
    end
    env_num = NUM_W'(env_prod);
  end

  // Offset, clamp at zero, rounding numerator and full-scale saturation of the output code.
  // The quotient by the weight sum comes from a reciprocal estimate that is
  // at most one low, corrected by one compare against the remainder.
  always_comb begin
    code_num      = CODE_BIAS + scale_prod;
    code_pos      = code_num[SCALE_W-1] ? '0 : SCALE_W'(code_num);
    code_x        = code_pos[SCALE_W-1:15];
    code_y        = (Y_W'(code_x) << DAC_BITS) + (Y_W'(WEIGHT_SUM) << 15);
    code_n        = code_y[16 +: N_W];
    code_rp       = RP_W'(code_n) * RP_W'(RECIP);
    code_rem_full = code_n - N_W'(code_q0) * N_W'(WEIGHT_SUM);
    code_q        = code_q0 + Q0_W'(code_rem >= {1'b0, WEIGHT_SUM});
    if (|code_q[Q0_W-1:DAC_BITS]) begin
      code_clamped = '1;
    end else begin
      code_clamped = code_q[DAC_BITS-1:0];
    end
  end

  // Sequencer, configuration registers and note state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      phase_step     <= PHASE_STEP_RST;
      attack_samples <= ATTACK_RST;
      decay_samples  <= DECAY_RST;
      phase_acc      <= '0;
      sample_time    <= '0;
      block_position <= '0;
      envelope_gain  <= GAIN_LOW;
      stage_latch    <= STAGE_ATTACK;
      issue_cnt      <= '0;
      rom_valid      <= 1'b0;
      prod_valid     <= 1'b0;
      div_cnt        <= '0;
    end else begin
      // Register writes.
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PHASE_STEP:     phase_step     <= cfg_data;
          REG_ATTACK_SAMPLES: attack_samples <= cfg_data[15:0];
          REG_DECAY_SAMPLES:  decay_samples  <= cfg_data[15:0];
          default: ;
        endcase
      end

      // The result leaves when the consumer takes it; the final state refills it itself.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      rom_valid  <= mac_issue;
      prod_valid <= rom_valid;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              phase_acc      <= '0;
              sample_time    <= '0;
              block_position <= '0;
            end
            state <= ST_ENV_SET;
          end
        end
        ST_ENV_SET: begin
          issue_cnt <= '0;
          div_cnt   <= '0;
          if (block_position != '0) begin
            state <= ST_MAC;
          end else if (env_in_attack) begin
            stage_latch <= STAGE_ATTACK;
            state       <= ST_ENV_DIV;
          end else if (env_in_decay) begin
            stage_latch <= STAGE_DECAY;
            state       <= ST_ENV_DIV;
          end else begin
            stage_latch   <= STAGE_SUSTAIN;
            envelope_gain <= GAIN_SUSTAIN;
            state         <= ST_MAC;
          end
        end
        ST_ENV_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_last) begin
            if (stage_latch == STAGE_ATTACK) begin
              envelope_gain <= GAIN_LOW + GAIN_W'(div_shift_next[GAIN_W-2:0]);
            end else begin
              envelope_gain <= GAIN_ONE - GAIN_W'(div_shift_next[GAIN_W-2:0]);
            end
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (mac_issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end else if (!rom_valid && !prod_valid) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_CODE_MUL;
        end
        ST_CODE_MUL: begin
          state <= ST_CODE_FIX;
        end
        ST_CODE_FIX: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Hand over the result and advance the note by one tick.
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            phase_acc   <= phase_acc + phase_step;
            if (sample_time != TIME_MAX) begin
              sample_time <= sample_time + 1'b1;
            end
            if (block_position == POS_W'(BLOCK_LEN - 1)) begin
              block_position <= '0;
            end else begin
              block_position <= block_position + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rom_data <= sine_rom[rom_addr];
    rom_widx <= WIDX_W'(issue_cnt);
    mac_prod <= MPROD_W'($signed({1'b0, WEIGHTS[rom_widx]})) * MPROD_W'(rom_data);

    // Harmonic phase walks h * phase_acc by repeated addition.
    if (state == ST_ENV_SET || state == ST_ENV_DIV) begin
      harm_phase <= phase_acc;
      mac_sum    <= '0;
    end else begin
      if (mac_issue) begin
        harm_phase <= harm_phase + phase_acc;
      end
      if (prod_valid) begin
        mac_sum <= mac_sum + SUM_W'(mac_prod);
      end
    end

    if (state == ST_SCALE) begin
      scale_prod <= SCALE_W'(mac_sum) * SCALE_W'($signed({1'b0, envelope_gain}));
    end

    // Divider load and steps.
    if (state == ST_ENV_SET) begin
      div_rem   <= env_num[NUM_W-1:QUO_W];
      div_shift <= env_num[QUO_W-1:0];
      div_den   <= env_den;
    end else if (state == ST_ENV_DIV) begin
      div_rem   <= div_rem_next;
      div_shift <= div_shift_next;
    end

    // Reciprocal estimate of the code, then the remainder that corrects it.
    if (state == ST_CODE_MUL) begin
      code_q0 <= code_rp[N_W +: Q0_W];
    end
    if (state == ST_CODE_FIX) begin
      code_rem <= code_rem_full[DIV_W:0];
    end

    // Output payload.
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      sample_code    <= code_clamped;
      envelope_stage <= stage_latch;
    end
  end

`ifndef SYNTH
  // A restart transaction puts the note back at its start.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && restart) |=>
      (phase_acc == '0 && sample_time == '0 && block_position == '0))
    else $error("restart did not clear the note state");

  // The envelope gain stays between the attack floor and unity.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (envelope_gain >= GAIN_LOW && envelope_gain <= GAIN_ONE))
    else $error("envelope gain out of range");

  // The accumulate pipeline is empty outside the harmonic loop.
  a_mac_drained: assert property (@(posedge clk) disable iff (rst)
    (state != ST_MAC) |-> (!rom_valid && !prod_valid))
    else $error("harmonic pipeline busy outside the loop");

  // A new result only appears from the final state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the final state");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for additive_harmonic_tone_synth_top at its default parameters.
// Holds an in-order predictor of sample codes and envelope stages, driven by directed
// and random ticks. Depends on ahts_pkg for port widths, register indexes and stage codes.
`timescale 1ns / 1ps

module tb;
  import ahts_pkg::*;

  localparam int CODE_W      = DEF_DAC_BITS;
  localparam int ROM_DEPTH   = 1024;
  localparam int BLOCK_TICKS = 128;
  localparam int HARMONICS   = 13;
  localparam int TIME_CAP    = 262143;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1000000;

  // Envelope levels in Q1.15.
  localparam longint START_LEVEL = 6554;
  localparam longint FULL_LEVEL  = 32768;
  localparam longint HOLD_LEVEL  = 26214;
  localparam longint RISE_SPAN   = 26214;
  localparam longint FALL_SPAN   = 6554;

  // Index past the last register; writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int HARMONIC_WEIGHT [HARMONICS] = '{
    32768, 25713, 27306, 24468, 13327, 13835, 10214, 8556, 6717, 4506, 3296, 2156, 1402
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [1:0]        stage;
  } tone_frame_t;

  typedef struct packed {
    bit                restart_bit;
    bit                typed;
    logic [CODE_W-1:0] code;
    logic [1:0]        stage;
  } tick_row_t;

  // Directed ticks at the reset configuration. Rows marked typed carry a known result:
  // phase zero always gives midscale.
  localparam int DIRECTED_N = 20;
  tick_row_t directed_ticks [DIRECTED_N] = '{
    '{1'b0, 1'b1, 10'd512, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b1, 1'b1, 10'd512, STAGE_ATTACK},
    '{1'b1, 1'b1, 10'd512, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b1, 1'b1, 10'd512, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK},
    '{1'b0, 1'b0, 10'd0, STAGE_ATTACK}
  };

  // Block ports; the inputs are known from time zero.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CODE_W-1:0]    sample_code;
  logic [1:0]           envelope_stage;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state and its copy of the registers.
  int          sine_table [ROM_DEPTH];
  logic [31:0] note_phase = '0;
  int          note_time = 0;
  int          block_pos = 0;
  longint      env_gain = START_LEVEL;
  logic [1:0]  env_stage = STAGE_ATTACK;
  logic [31:0] step_reg = 32'd407486240;
  int          attack_reg = 827;
  int          decay_reg = 3307;

  tone_frame_t pending_frames [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  additive_harmonic_tone_synth_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_code    (sample_code),
    .envelope_stage (envelope_stage),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // Sine magnitude for a first-quadrant step r of the table, Taylor series in Q30.
  function automatic int quadrant_sine(longint unsigned r);
    longint unsigned angle;
    longint unsigned term;
    longint unsigned divisor;
    longint          acc;
    angle = (r * 64'd1686629713) / ROM_DEPTH;
    term  = angle;
    acc   = longint'(angle);
    for (int k = 1; k <= 6; k++) begin
      divisor = longint'(2 * k * (2 * k + 1));
      term = (term * angle) >> 30;
      term = (term * angle) >> 30;
      term = term / divisor;
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return int'(acc);
  endfunction

  // Full-wave table built by folding the first quadrant.
  function automatic void build_sine_table();
    int quadrant;
    int r;
    int mag;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      quadrant = (4 * k) / ROM_DEPTH;
      r = (4 * k) % ROM_DEPTH;
      if (quadrant % 2 == 1) begin
        r = ROM_DEPTH - r;
      end
      mag = quadrant_sine(longint'(r));
      sine_table[k] = (quadrant >= 2) ? -mag : mag;
    end
  endfunction

  // Envelope gain and stage taken at the first tick of a block.
  function automatic void latch_envelope();
    if (note_time < attack_reg) begin
      env_gain  = START_LEVEL + (RISE_SPAN * note_time) / attack_reg;
      env_stage = STAGE_ATTACK;
    end else if (note_time < attack_reg + decay_reg) begin
      env_gain  = FULL_LEVEL - (FALL_SPAN * (note_time - attack_reg)) / decay_reg;
      env_stage = STAGE_DECAY;
    end else begin
      env_gain  = HOLD_LEVEL;
      env_stage = STAGE_SUSTAIN;
    end
  endfunction

  // One sample tick: mix the harmonics, apply the envelope, scale to a DAC code.
  function automatic tone_frame_t next_tone_frame(bit restart_bit);
    tone_frame_t frame;
    logic [31:0] harm_phase;
    longint      mix;
    longint      weight_sum;
    longint      num;
    longint      scaled;
    longint      den;
    longint      code;
    mix = 0;
    weight_sum = 0;
    if (restart_bit) begin
      note_phase = '0;
      note_time  = 0;
      block_pos  = 0;
    end
    if (block_pos == 0) begin
      latch_envelope();
    end
    for (int h = 1; h <= HARMONICS; h++) begin
      harm_phase = 32'(h) * note_phase;
      mix = mix + longint'(HARMONIC_WEIGHT[h-1]) * longint'(sine_table[harm_phase[31:22]]);
      weight_sum = weight_sum + HARMONIC_WEIGHT[h-1];
    end
    num = weight_sum * (longint'(1) << 30) + mix * env_gain;
    if (num < 0) begin
      num = 0;
    end
    scaled = num >>> 15;
    den = 2 * weight_sum * 32768;
    code = ((scaled << CODE_W) + den / 2) / den;
    if (code > (1 << CODE_W) - 1) begin
      code = (1 << CODE_W) - 1;
    end
    frame.code  = CODE_W'(code);
    frame.stage = env_stage;
    // Advance time, phase and block position.
    note_phase = note_phase + step_reg;
    if (note_time < TIME_CAP) begin
      note_time++;
    end
    block_pos = (block_pos + 1) % BLOCK_TICKS;
    return frame;
  endfunction

  // Register write; the block must be idle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PHASE_STEP:     step_reg = data;
      REG_ATTACK_SAMPLES: attack_reg = int'(data[15:0]);
      REG_DECAY_SAMPLES:  decay_reg = int'(data[15:0]);
      default: ;
    endcase
  endtask

  // Drop valid and wait until every expected sample has come back.
  task automatic wait_for_silence();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one tick transaction after a random gap and log its expected sample.
  task automatic send_tick(input bit restart_bit, input bit typed, input tone_frame_t known);
    tone_frame_t predicted;
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    restart  <= restart_bit;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = next_tone_frame(restart_bit);
    pending_frames.push_back(typed ? known : predicted);
  endtask

  // A run of random ticks; each phase starts its note afresh.
  task automatic play_phase(input int idle_pct, input int stall_pct, input int restart_pct,
                            input int count);
    bit restart_bit;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      restart_bit = (i == 0) || ($urandom_range(99) < restart_pct);
      if ($urandom_range(99) < 2) begin
        wait_for_silence();
      end
      send_tick(restart_bit, 1'b0, '0);
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted sample with the oldest expectation.
  always @(posedge clk) begin
    tone_frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: sample with none expected: code %0d stage %0d", $time, sample_code,
                 envelope_stage);
        mismatch_count++;
      end else begin
        want = pending_frames.pop_front();
        if (sample_code !== want.code) begin
          $display("%0t: sample_code expected %0d, got %0d", $time, want.code, sample_code);
          mismatch_count++;
        end
        if (envelope_stage !== want.stage) begin
          $display("%0t: envelope_stage expected %0d, got %0d", $time, want.stage,
                   envelope_stage);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d samples outstanding", $time, pending_frames.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    build_sine_table();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset configuration, no idling.
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_tick(directed_ticks[i].restart_bit, directed_ticks[i].typed,
                '{directed_ticks[i].code, directed_ticks[i].stage});
    end
    wait_for_silence();

    // Slowest phase step, shortest envelope: one-sample attack and decay.
    write_reg(REG_PHASE_STEP, 32'd1);
    write_reg(REG_ATTACK_SAMPLES, 32'd1);
    write_reg(REG_DECAY_SAMPLES, 32'd1);
    play_phase(0, 0, 1, 100);
    wait_for_silence();

    // Half-turn step; upper data bits of the length registers are dropped.
    write_reg(REG_PHASE_STEP, 32'h8000_0000);
    write_reg(REG_ATTACK_SAMPLES, 32'hABCD_0064);
    write_reg(REG_DECAY_SAMPLES, 32'h0001_0096);
    play_phase(80, 0, 1, 100);
    wait_for_silence();

    // Full-scale step, attack skipped, longest decay; the spare index changes nothing.
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_ATTACK_SAMPLES, 32'd0);
    write_reg(REG_DECAY_SAMPLES, 32'd65535);
    write_reg(REG_SPARE, $urandom);
    play_phase(0, 80, 1, 100);
    wait_for_silence();

    // Random step, longest attack, decay skipped.
    write_reg(REG_PHASE_STEP, $urandom);
    write_reg(REG_ATTACK_SAMPLES, 32'd65535);
    write_reg(REG_DECAY_SAMPLES, 32'd0);
    play_phase(38, 38, 1, 100);
    wait_for_silence();

    // Frozen phase, no envelope ramps, frequent restarts.
    write_reg(REG_PHASE_STEP, 32'd0);
    write_reg(REG_ATTACK_SAMPLES, 32'd0);
    write_reg(REG_DECAY_SAMPLES, 32'd0);
    play_phase(0, 0, 25, 100);
    wait_for_silence();

    // Random step with short random attack and decay ramps.
    write_reg(REG_PHASE_STEP, $urandom);
    write_reg(REG_ATTACK_SAMPLES, $urandom_range(200, 1));
    write_reg(REG_DECAY_SAMPLES, $urandom_range(200, 1));
    play_phase(38, 38, 2, 100);
    wait_for_silence();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
